// File: rtl/pbe_pkg.sv
// package for the protobuf length-delimited field encoder
// holds the action codes, queue command type, back-end states and sizes
// no dependencies
package pbe_pkg;

  localparam int QueueDepth = 4;
  localparam int PtrW = $clog2(QueueDepth);
  localparam int CountW = $clog2(QueueDepth + 1);

  typedef enum logic [1:0] {
    ACT_START   = 2'd0,
    ACT_PAYLOAD = 2'd1,
    ACT_END     = 2'd2,
    ACT_RSVD    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_BYTE  = 2'd1,
    CMD_END   = 2'd2
  } cmd_kind_t;

  localparam logic [2:0] WireTypeLen = 3'b010;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [31:0] tag;
    logic [63:0] len;
    logic [7:0]  data;
    logic        done;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_TAG,
    BK_LEN
  } back_state_t;

endpackage

// File: rtl/pbe_front.sv
// front end of the encoder: takes input transfers and classifies them
// keeps the remaining payload byte count and pushes commands; uses pbe_pkg
module pbe_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  logic [1:0]           action,
  input  logic [28:0]          field_id,
  input  logic [63:0]          value_length,
  input  logic [7:0]           payload_byte,
  input  logic                 q_full,
  output logic                 q_push,
  output pbe_pkg::cmd_t        q_cmd
);

  logic [63:0] bytes_remaining;
  logic [63:0] bytes_remaining_next;
  logic        accept;
  logic        have_bytes;

  assign item_stall = q_full;
  assign accept     = item_valid && !q_full;
  assign have_bytes = |bytes_remaining;

  always_comb begin
    bytes_remaining_next = bytes_remaining;
    q_push               = 1'b0;
    q_cmd.kind           = pbe_pkg::CMD_BYTE;
    q_cmd.tag            = {field_id, pbe_pkg::WireTypeLen};
    q_cmd.len            = value_length;
    q_cmd.data           = payload_byte;
    q_cmd.done           = (bytes_remaining == 64'd1);
    if (accept) begin
      unique case (pbe_pkg::action_t'(action))
        pbe_pkg::ACT_START: begin
          q_push               = 1'b1;
          q_cmd.kind           = pbe_pkg::CMD_START;
          bytes_remaining_next = value_length;
        end
        pbe_pkg::ACT_PAYLOAD: begin
          if (have_bytes) begin
            q_push               = 1'b1;
            q_cmd.kind           = pbe_pkg::CMD_BYTE;
            bytes_remaining_next = bytes_remaining - 64'd1;
          end
        end
        pbe_pkg::ACT_END: begin
          q_push               = 1'b1;
          q_cmd.kind           = pbe_pkg::CMD_END;
          bytes_remaining_next = '0;
        end
        default: begin
          q_push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_remaining <= '0;
    end else begin
      bytes_remaining <= bytes_remaining_next;
    end
  end

endmodule

// File: rtl/pbe_queue.sv
// short command queue between the front and back ends
// register array with read and write pointers; uses pbe_pkg
module pbe_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pbe_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output pbe_pkg::cmd_t pop_cmd,
  output logic          empty
);

  pbe_pkg::cmd_t                mem [pbe_pkg::QueueDepth];
  logic [pbe_pkg::PtrW-1:0]     wr_ptr;
  logic [pbe_pkg::PtrW-1:0]     rd_ptr;
  logic [pbe_pkg::CountW-1:0]   count;
  logic                         do_push;
  logic                         do_pop;

  assign full    = (count == pbe_pkg::CountW'(pbe_pkg::QueueDepth));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + pbe_pkg::PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + pbe_pkg::PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + pbe_pkg::CountW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - pbe_pkg::CountW'(1);
      end
    end
  end

endmodule

// File: rtl/pbe_back.sv
// back end of the encoder: runs queued commands and drives the output register
// emits tag and length varints one group per cycle while the output is not stalled; uses pbe_pkg
module pbe_back (
  input  logic          clk,
  input  logic          rst,
  input  pbe_pkg::cmd_t q_cmd,
  input  logic          q_empty,
  output logic          q_pop,
  output logic          result_valid,
  input  logic          result_stall,
  output logic [7:0]    out_byte,
  output logic          byte_valid,
  output logic          last_in_run,
  output logic          end_of_message,
  output logic          field_done
);

  pbe_pkg::back_state_t state;
  pbe_pkg::back_state_t state_next;
  logic [63:0]          shift;
  logic [63:0]          shift_next;
  logic [63:0]          len_hold;
  logic                 len_zero;
  logic                 load_start;
  logic                 adv;
  logic                 emit;
  logic                 more;
  logic [7:0]           e_byte;
  logic                 e_bv;
  logic                 e_last;
  logic                 e_eom;
  logic                 e_done;

  assign adv  = !result_valid || !result_stall;
  assign more = |shift[63:7];

  always_comb begin
    state_next = state;
    shift_next = shift;
    q_pop      = 1'b0;
    load_start = 1'b0;
    emit       = 1'b0;
    e_byte     = {more, shift[6:0]};
    e_bv       = 1'b1;
    e_last     = 1'b0;
    e_eom      = 1'b0;
    e_done     = 1'b0;
    if (adv) begin
      unique case (state)
        pbe_pkg::BK_IDLE: begin
          if (!q_empty) begin
            q_pop = 1'b1;
            unique case (q_cmd.kind)
              pbe_pkg::CMD_START: begin
                load_start = 1'b1;
                shift_next = {32'd0, q_cmd.tag};
                state_next = pbe_pkg::BK_TAG;
              end
              pbe_pkg::CMD_BYTE: begin
                emit   = 1'b1;
                e_byte = q_cmd.data;
                e_last = 1'b1;
                e_done = q_cmd.done;
              end
              default: begin
                emit   = 1'b1;
                e_byte = '0;
                e_bv   = 1'b0;
                e_last = 1'b1;
                e_eom  = 1'b1;
              end
            endcase
          end
        end
        pbe_pkg::BK_TAG: begin
          emit = 1'b1;
          if (more) begin
            shift_next = {7'd0, shift[63:7]};
          end else begin
            shift_next = len_hold;
            state_next = pbe_pkg::BK_LEN;
          end
        end
        pbe_pkg::BK_LEN: begin
          emit = 1'b1;
          if (more) begin
            shift_next = {7'd0, shift[63:7]};
          end else begin
            e_last     = 1'b1;
            e_done     = len_zero;
            state_next = pbe_pkg::BK_IDLE;
          end
        end
        default: begin
          state_next = pbe_pkg::BK_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= pbe_pkg::BK_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (adv) begin
        result_valid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    shift <= shift_next;
    if (load_start) begin
      len_hold <= q_cmd.len;
      len_zero <= (q_cmd.len == 64'd0);
    end
    if (adv && emit) begin
      out_byte       <= e_byte;
      byte_valid     <= e_bv;
      last_in_run    <= e_last;
      end_of_message <= e_eom;
      field_done     <= e_done;
    end
  end

endmodule

// File: rtl/protobuf_length_delimited_field_encoder_unit.sv
// top level of the protobuf length-delimited field encoder
// joins pbe_front, pbe_queue and pbe_back; uses pbe_pkg
//
//  channel | handshake                 | payload
//  input   | item_valid / item_stall   | action, field_id, value_length, payload_byte
//  output  | result_valid/result_stall | out_byte, byte_valid, last_in_run,
//          |                           | end_of_message, field_done
//
// payload and end-of-row items are emitted straight from the idle state of the back end
// a field start first loads the tag and length, then emits the tag and the length varint groups
// the back end varint shifter sets the rate; a 4-entry queue decouples the input
// rst clears the byte count, empties the queue and clears result_valid; no clearing pass
// item_stall rises only when the queue is full; result_stall holds a valid output register
module protobuf_length_delimited_field_encoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [1:0]  action,
  input  logic [28:0] field_id,
  input  logic [63:0] value_length,
  input  logic [7:0]  payload_byte,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [7:0]  out_byte,
  output logic        byte_valid,
  output logic        last_in_run,
  output logic        end_of_message,
  output logic        field_done
);

  pbe_pkg::cmd_t push_cmd;
  pbe_pkg::cmd_t pop_cmd;
  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_empty;

  pbe_front u_front (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .action       (action),
    .field_id     (field_id),
    .value_length (value_length),
    .payload_byte (payload_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (push_cmd)
  );

  pbe_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty)
  );

  pbe_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_cmd          (pop_cmd),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .out_byte       (out_byte),
    .byte_valid     (byte_valid),
    .last_in_run    (last_in_run),
    .end_of_message (end_of_message),
    .field_done     (field_done)
  );

  // a bare result is always a row end and closes its run
  a_bare_is_eom: assert property (@(posedge clk) disable iff (rst)
    result_valid && !byte_valid |-> end_of_message && last_in_run)
    else $error("bare result without row end");

  // a row end never carries a byte or finishes a field
  a_eom_bare: assert property (@(posedge clk) disable iff (rst)
    result_valid && end_of_message |-> !byte_valid && !field_done)
    else $error("row end carries a byte");

  // nothing comes out in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst && $past(rst) |-> !result_valid)
    else $error("result after reset");

endmodule

// File: test/tb_protobuf_length_delimited_field_encoder_unit.sv
// self-checking testbench for protobuf_length_delimited_field_encoder_unit
// predicts tag and length varints and payload pass-through, checks every output transfer
// depends on pbe_pkg and the encoder rtl
module tb_protobuf_length_delimited_field_encoder_unit;

  localparam int CycleLimit  = 300000;
  localparam int DrainCycles = 40;
  localparam int ReportMax   = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
    logic       eom;
    logic       done;
  } enc_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  logic [1:0]  action = 2'b00;
  logic [28:0] field_id = '0;
  logic [63:0] value_length = '0;
  logic [7:0]  payload_byte = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic        last_in_run;
  logic        end_of_message;
  logic        field_done;

  enc_result_t expected_stream[$];
  logic [63:0] field_bytes_left = '0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          items_sent = 0;
  int          mismatches = 0;
  int          cycle_count = 0;

  protobuf_length_delimited_field_encoder_unit uut (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .action         (action),
    .field_id       (field_id),
    .value_length   (value_length),
    .payload_byte   (payload_byte),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .out_byte       (out_byte),
    .byte_valid     (byte_valid),
    .last_in_run    (last_in_run),
    .end_of_message (end_of_message),
    .field_done     (field_done)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    while (cycle_count <= CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d transfers outstanding", cycle_count,
             expected_stream.size());
    $display("*** FAILED ***");
    $finish;
  end

  function automatic enc_result_t mk_result(input logic [7:0] d, input logic v, input logic l,
                                            input logic e, input logic dn);
    return {d, v, l, e, dn};
  endfunction

  function automatic void queue_expect(input enc_result_t r);
    expected_stream.insert(expected_stream.size(), r);
  endfunction

  function automatic void encode_item(input pbe_pkg::action_t act, input logic [28:0] fnum,
                                      input logic [63:0] len, input logic [7:0] pb);
    logic [31:0] tag_v;
    logic [63:0] len_v;
    case (act)
      pbe_pkg::ACT_START: begin
        tag_v = {fnum, pbe_pkg::WireTypeLen};
        while (tag_v >= 32'h80) begin
          queue_expect(mk_result({1'b1, tag_v[6:0]}, 1'b1, 1'b0, 1'b0, 1'b0));
          tag_v = tag_v >> 7;
        end
        queue_expect(mk_result({1'b0, tag_v[6:0]}, 1'b1, 1'b0, 1'b0, 1'b0));
        len_v = len;
        while (len_v >= 64'h80) begin
          queue_expect(mk_result({1'b1, len_v[6:0]}, 1'b1, 1'b0, 1'b0, 1'b0));
          len_v = len_v >> 7;
        end
        queue_expect(mk_result({1'b0, len_v[6:0]}, 1'b1, 1'b1, 1'b0, len == 0));
        field_bytes_left = len;
      end
      pbe_pkg::ACT_PAYLOAD: begin
        if (field_bytes_left != 0) begin
          field_bytes_left = field_bytes_left - 1;
          queue_expect(mk_result(pb, 1'b1, 1'b1, 1'b0, field_bytes_left == 0));
        end
      end
      pbe_pkg::ACT_END: begin
        field_bytes_left = '0;
        queue_expect(mk_result(8'h00, 1'b0, 1'b1, 1'b1, 1'b0));
      end
      default: begin
      end
    endcase
  endfunction

  task automatic send_item(input pbe_pkg::action_t act, input logic [28:0] fnum,
                           input logic [63:0] len, input logic [7:0] pb);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid   <= 1'b1;
    action       <= act;
    field_id     <= fnum;
    value_length <= len;
    payload_byte <= pb;
    do @(posedge clk); while (item_stall);
    encode_item(act, fnum, len, pb);
    items_sent++;
  endtask

  // output side: check accepted transfers, then pick the stall for the next cycle
  initial begin
    enc_result_t got;
    enc_result_t want;
    forever begin
      @(posedge clk);
      if (!rst && result_valid === 1'b1 && !result_stall) begin
        got = {out_byte, byte_valid, last_in_run, end_of_message, field_done};
        if (expected_stream.size() == 0) begin
          mismatches++;
          if (mismatches <= ReportMax)
            $display("unexpected transfer: byte %02h valid %b last %b eom %b done %b",
                     got.data, got.valid, got.last, got.eom, got.done);
        end else begin
          want = expected_stream.pop_front();
          if (got.data !== want.data || got.valid !== want.valid || got.last !== want.last ||
              got.eom !== want.eom || got.done !== want.done) begin
            mismatches++;
            if (mismatches <= ReportMax) begin
              $write("mismatch: expected byte %02h valid %b last %b eom %b done %b, ",
                     want.data, want.valid, want.last, want.eom, want.done);
              $display("got byte %02h valid %b last %b eom %b done %b",
                       got.data, got.valid, got.last, got.eom, got.done);
            end
          end
        end
      end
      result_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  function automatic logic [28:0] rand_field_id();
    case ($urandom_range(9))
      0:       return 29'h1FFF_FFFF;
      1, 2:    return 29'($urandom) | 29'd1;
      default: return 29'($urandom_range(1, 40));
    endcase
  endfunction

  function automatic logic [63:0] rand_length();
    case ($urandom_range(9))
      7:       return 64'($urandom_range(120, 300));
      8, 9:    return {$urandom, $urandom} >> $urandom_range(0, 63);
      default: return 64'($urandom_range(0, 6));
    endcase
  endfunction

  task automatic test_tag_and_length_extremes();
    send_item(pbe_pkg::ACT_START, 29'd1, 64'd0, 8'h00);
    send_item(pbe_pkg::ACT_START, 29'h1FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00);
    send_item(pbe_pkg::ACT_START, 29'd15, 64'd127, 8'h00);
    send_item(pbe_pkg::ACT_START, 29'd16, 64'd128, 8'h00);
    // field number zero gives a bare wire-type tag
    send_item(pbe_pkg::ACT_START, 29'd0, 64'h8000_0000_0000_0000, 8'h00);
    send_item(pbe_pkg::ACT_END, 29'd0, 64'd0, 8'h00);
  endtask

  task automatic test_payload_stream();
    // empty message
    send_item(pbe_pkg::ACT_END, 29'd0, 64'd0, 8'h00);
    send_item(pbe_pkg::ACT_START, 29'd3, 64'd3, 8'h00);
    send_item(pbe_pkg::ACT_PAYLOAD, 29'd0, 64'd0, 8'h00);
    send_item(pbe_pkg::ACT_PAYLOAD, 29'd0, 64'd0, 8'hFF);
    send_item(pbe_pkg::ACT_PAYLOAD, 29'd0, 64'd0, 8'hA5);
    send_item(pbe_pkg::ACT_END, 29'd0, 64'd0, 8'h00);
  endtask

  task automatic test_special_cases();
    // stray byte with no open field
    send_item(pbe_pkg::ACT_PAYLOAD, 29'd0, 64'd0, 8'h5A);
    // new start abandons an open field
    send_item(pbe_pkg::ACT_START, 29'd2, 64'd4, 8'h00);
    send_item(pbe_pkg::ACT_PAYLOAD, 29'd0, 64'd0, 8'h11);
    send_item(pbe_pkg::ACT_START, 29'd3, 64'd1, 8'h00);
    send_item(pbe_pkg::ACT_PAYLOAD, 29'd0, 64'd0, 8'h22);
    send_item(pbe_pkg::ACT_PAYLOAD, 29'd0, 64'd0, 8'h33);
    // row end while a field is open
    send_item(pbe_pkg::ACT_START, 29'd4, 64'd3, 8'h00);
    send_item(pbe_pkg::ACT_PAYLOAD, 29'd0, 64'd0, 8'h44);
    send_item(pbe_pkg::ACT_END, 29'd0, 64'd0, 8'h00);
    send_item(pbe_pkg::ACT_PAYLOAD, 29'd0, 64'd0, 8'h55);
    // reserved action code
    send_item(pbe_pkg::ACT_RSVD, 29'h1FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF);
  endtask

  task automatic test_random_rows(input int target, input int s_pct, input int r_pct);
    int          goal;
    int          nfields;
    logic [63:0] len;
    logic [63:0] k;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    goal = items_sent + target;
    while (items_sent < goal) begin
      if ($urandom_range(99) < 12) begin
        case ($urandom_range(3))
          0: send_item(pbe_pkg::ACT_RSVD, rand_field_id(), rand_length(), 8'($urandom));
          1: send_item(pbe_pkg::ACT_PAYLOAD, rand_field_id(), rand_length(), 8'($urandom));
          2: begin
            // truncated field, left open for the next item
            len = 64'($urandom_range(2, 6));
            send_item(pbe_pkg::ACT_START, rand_field_id(), len, 8'($urandom));
            repeat (int'(len) - 1)
              send_item(pbe_pkg::ACT_PAYLOAD, rand_field_id(), rand_length(), 8'($urandom));
          end
          default: send_item(pbe_pkg::ACT_END, rand_field_id(), rand_length(), 8'($urandom));
        endcase
      end else begin
        nfields = $urandom_range(0, 4);
        repeat (nfields) begin
          len = rand_length();
          send_item(pbe_pkg::ACT_START, rand_field_id(), len, 8'($urandom));
          for (k = 0; k < len && k < 10; k++)
            send_item(pbe_pkg::ACT_PAYLOAD, rand_field_id(), rand_length(), 8'($urandom));
        end
        send_item(pbe_pkg::ACT_END, rand_field_id(), rand_length(), 8'($urandom));
      end
    end
  endtask

  initial begin
    send_idle_pct = 35;
    recv_idle_pct = 47;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_tag_and_length_extremes();
    test_payload_stream();
    test_special_cases();
    test_random_rows(56, 35, 47);
    test_random_rows(56, 47, 35);
    test_random_rows(56, 0, 0);
    item_valid <= 1'b0;
    while (expected_stream.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0 && expected_stream.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
